FILE: rtl/rip_pkg.sv
// Shared types, constants and the digit decoder for the radix integer parser.
package rip_pkg;

    localparam int CHAR_W  = 8;
    localparam int BASE_W  = 6;
    localparam int VALUE_W = 64;
    localparam int END_W   = 13;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;
    localparam int REG_W   = ADDR_W - 2;

    // Register index, taken from the word address bits of paddr.
    localparam logic [REG_W-1:0] REG_RADIX = '0;

    localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [BASE_W-1:0] RADIX_ONE   = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT    = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC    = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX    = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX    = 6'd36;
    localparam logic [BASE_W-1:0] DIGIT_NONE  = 6'd63;
    localparam logic [BASE_W-1:0] ALPHA_OFS   = 6'd10;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

    localparam logic [VALUE_W-1:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] LIM_NEG = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_BAD_RADIX = 2'd2
    } t_status;

    // Commands from the controller to the datapath for the byte accepted this cycle.
    typedef struct packed {
        logic              step;
        logic              set_err;
        logic              count;
        logic              set_sign;
        logic              stop_here;
        logic              take;
        logic              base_wr;
        logic [BASE_W-1:0] base_val;
        logic              emit;
    } t_dp_cmd;

    // Classification of the current byte and datapath state for the controller.
    typedef struct packed {
        logic first;
        logic radix_bad;
        logic at_max;
        logic is_nul;
        logic is_space;
        logic is_sign;
        logic is_minus;
        logic is_zero;
        logic is_x;
        logic base_now0;
        logic base_now16;
        logic ok_now;
        logic ok_dec;
        logic ok_oct;
    } t_dp_status;

    // Digit value of a character, case-insensitive; DIGIT_NONE for anything else.
    function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        lc = c;
        if (c >= CH_UA && c <= CH_UZ) begin
            lc = c + CASE_OFS;
        end
        if (c >= CH_0 && c <= CH_9) begin
            return BASE_W'(c - CH_0);
        end else if (lc >= CH_LA && lc <= CH_LZ) begin
            return BASE_W'(lc - CH_LA) + ALPHA_OFS;
        end else begin
            return DIGIT_NONE;
        end
    endfunction

endpackage

FILE: rtl/rip_datapath.sv
// Datapath of the radix integer parser: accumulator, counters and result register.
module rip_datapath #(
    parameter int MAX_LEN = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rip_pkg::CHAR_W-1:0]    i_char,
    input  logic [rip_pkg::BASE_W-1:0]    i_radix,
    input  rip_pkg::t_dp_cmd              i_cmd,
    output rip_pkg::t_dp_status           o_status,
    output logic signed [rip_pkg::VALUE_W-1:0] o_value,
    output logic [rip_pkg::END_W-1:0]     o_end_pos,
    output logic [1:0]                    o_status_code
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int EXT_W  = (CNT_W > rip_pkg::END_W) ? CNT_W : rip_pkg::END_W;
    localparam int PROD_W = rip_pkg::VALUE_W + rip_pkg::BASE_W;
    localparam int SUM_W  = PROD_W + 1;

    logic                         r_started, n_started;
    logic [rip_pkg::BASE_W-1:0]   r_eff_base, n_eff_base;
    logic [rip_pkg::VALUE_W-1:0]  r_mag, n_mag;
    logic                         r_neg, n_neg;
    logic                         r_ovf, n_ovf;
    logic                         r_err, n_err;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [CNT_W-1:0]             r_stop, n_stop;

    logic [rip_pkg::VALUE_W-1:0]  r_out_mag;
    logic                         r_out_neg;
    logic                         r_out_ovf;
    logic                         r_out_err;
    logic [CNT_W-1:0]             r_out_stop;

    logic [rip_pkg::BASE_W-1:0]   base_now;
    logic [rip_pkg::BASE_W-1:0]   work_base;
    logic [rip_pkg::BASE_W-1:0]   digit;
    logic [PROD_W-1:0]            prod;
    logic [SUM_W-1:0]             sum;
    logic [rip_pkg::VALUE_W-1:0]  limit;
    logic                         ovf_now;
    logic [EXT_W-1:0]             stop_ext;

    assign base_now  = r_started ? r_eff_base : i_radix;
    assign work_base = i_cmd.base_wr ? i_cmd.base_val : base_now;
    assign digit     = rip_pkg::digit_value(i_char);

    // One multiply-accumulate step with an exact range check against the signed limit.
    assign prod    = PROD_W'(r_mag) * PROD_W'(work_base);
    assign sum     = SUM_W'(prod) + SUM_W'(digit);
    assign limit   = r_neg ? rip_pkg::LIM_NEG : rip_pkg::LIM_POS;
    assign ovf_now = sum > SUM_W'(limit);

    always_comb begin
        o_status.first      = !r_started;
        o_status.radix_bad  = (i_radix == rip_pkg::RADIX_ONE) || (i_radix > rip_pkg::BASE_MAX);
        o_status.at_max     = (r_cnt == CNT_W'(MAX_LEN));
        o_status.is_nul     = (i_char == rip_pkg::CH_NUL);
        o_status.is_space   = (i_char == rip_pkg::CH_SPACE) ||
                              (i_char >= rip_pkg::CH_TAB && i_char <= rip_pkg::CH_CR);
        o_status.is_sign    = (i_char == rip_pkg::CH_PLUS) || (i_char == rip_pkg::CH_MINUS);
        o_status.is_minus   = (i_char == rip_pkg::CH_MINUS);
        o_status.is_zero    = (i_char == rip_pkg::CH_0);
        o_status.is_x       = (i_char == rip_pkg::CH_LX) || (i_char == rip_pkg::CH_UX);
        o_status.base_now0  = (base_now == '0);
        o_status.base_now16 = (base_now == rip_pkg::BASE_HEX);
        o_status.ok_now     = (base_now != '0) && (digit < base_now);
        o_status.ok_dec     = (digit < rip_pkg::BASE_DEC);
        o_status.ok_oct     = (digit < rip_pkg::BASE_OCT);
    end

    always_comb begin
        n_started  = r_started;
        n_eff_base = r_eff_base;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_ovf      = r_ovf;
        n_err      = r_err;
        n_cnt      = r_cnt;
        n_stop     = r_stop;
        if (i_cmd.step) begin
            n_started  = 1'b1;
            n_eff_base = work_base;
            if (i_cmd.count) begin
                n_cnt = r_cnt + 1'b1;
            end
            if (i_cmd.set_err) begin
                n_err = 1'b1;
            end
            if (i_cmd.set_sign) begin
                n_neg = o_status.is_minus;
            end
            if (i_cmd.stop_here) begin
                n_stop = r_cnt + 1'b1;
            end
            if (i_cmd.take && !r_ovf) begin
                if (ovf_now) begin
                    n_ovf = 1'b1;
                end else begin
                    n_mag = sum[rip_pkg::VALUE_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started  <= 1'b0;
            r_eff_base <= '0;
            r_mag      <= '0;
            r_neg      <= 1'b0;
            r_ovf      <= 1'b0;
            r_err      <= 1'b0;
            r_cnt      <= '0;
            r_stop     <= '0;
        end else if (i_cmd.emit) begin
            r_started  <= 1'b0;
            r_eff_base <= '0;
            r_mag      <= '0;
            r_neg      <= 1'b0;
            r_ovf      <= 1'b0;
            r_err      <= 1'b0;
            r_cnt      <= '0;
            r_stop     <= '0;
        end else begin
            r_started  <= n_started;
            r_eff_base <= n_eff_base;
            r_mag      <= n_mag;
            r_neg      <= n_neg;
            r_ovf      <= n_ovf;
            r_err      <= n_err;
            r_cnt      <= n_cnt;
            r_stop     <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_mag  <= n_mag;
            r_out_neg  <= n_neg;
            r_out_ovf  <= n_ovf;
            r_out_err  <= n_err;
            r_out_stop <= n_stop;
        end
    end

    assign stop_ext = EXT_W'(r_out_stop);

    always_comb begin
        if (r_out_err) begin
            o_value       = '0;
            o_end_pos     = '0;
            o_status_code = rip_pkg::ST_BAD_RADIX;
        end else if (r_out_ovf) begin
            o_value       = $signed(r_out_neg ? rip_pkg::LIM_NEG : rip_pkg::LIM_POS);
            o_end_pos     = stop_ext[rip_pkg::END_W-1:0];
            o_status_code = rip_pkg::ST_RANGE;
        end else begin
            o_value       = $signed(r_out_neg ? (-r_out_mag) : r_out_mag);
            o_end_pos     = stop_ext[rip_pkg::END_W-1:0];
            o_status_code = rip_pkg::ST_OK;
        end
    end

endmodule

FILE: rtl/rip_ctrl.sv
// Controller of the radix integer parser: scan phase machine and channel handshake.
module rip_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_last,
    input  logic                  i_out_ready,
    input  rip_pkg::t_dp_status   i_status,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    output rip_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        PH_WS,
        PH_LEAD,
        PH_ZERO,
        PH_HEX,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    t_phase r_phase, n_phase;
    logic   r_out_valid, n_out_valid;
    logic   acc;
    logic   lead_req;
    logic   take_req;
    logic   take_ok;

    // Only a final byte needs the result register, so other bytes pass a waiting result.
    assign o_in_ready  = !r_out_valid || i_out_ready || !i_last;
    assign o_out_valid = r_out_valid;
    assign acc         = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd    = '0;
        n_phase  = r_phase;
        lead_req = 1'b0;
        take_req = 1'b0;
        take_ok  = 1'b0;
        if (acc) begin
            o_cmd.step = 1'b1;
            if (i_status.first && i_status.radix_bad) begin
                o_cmd.set_err = 1'b1;
                n_phase       = PH_DONE;
            end
            if (n_phase != PH_DONE) begin
                if (i_status.is_nul || i_status.at_max) begin
                    n_phase = PH_DONE;
                end else begin
                    o_cmd.count = 1'b1;
                    case (n_phase)
                        PH_WS: begin
                            if (i_status.is_space) begin
                                n_phase = PH_WS;
                            end else if (i_status.is_sign) begin
                                o_cmd.set_sign  = 1'b1;
                                o_cmd.stop_here = 1'b1;
                                n_phase         = PH_LEAD;
                            end else begin
                                lead_req = 1'b1;
                            end
                        end
                        PH_LEAD: begin
                            lead_req = 1'b1;
                        end
                        PH_ZERO: begin
                            if (i_status.is_x) begin
                                o_cmd.base_wr  = 1'b1;
                                o_cmd.base_val = rip_pkg::BASE_HEX;
                                n_phase        = PH_HEX;
                            end else begin
                                take_req = 1'b1;
                                if (i_status.base_now0) begin
                                    o_cmd.base_wr  = 1'b1;
                                    o_cmd.base_val = rip_pkg::BASE_OCT;
                                    take_ok        = i_status.ok_oct;
                                end else begin
                                    take_ok = i_status.ok_now;
                                end
                            end
                        end
                        default: begin
                            take_req = 1'b1;
                            take_ok  = i_status.ok_now;
                        end
                    endcase
                    if (lead_req) begin
                        if (i_status.is_zero && (i_status.base_now0 || i_status.base_now16)) begin
                            o_cmd.stop_here = 1'b1;
                            n_phase         = PH_ZERO;
                        end else begin
                            take_req = 1'b1;
                            if (i_status.base_now0) begin
                                o_cmd.base_wr  = 1'b1;
                                o_cmd.base_val = rip_pkg::BASE_DEC;
                                take_ok        = i_status.ok_dec;
                            end else begin
                                take_ok = i_status.ok_now;
                            end
                        end
                    end
                    if (take_req) begin
                        if (take_ok) begin
                            o_cmd.take      = 1'b1;
                            o_cmd.stop_here = 1'b1;
                            n_phase         = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
            if (i_last) begin
                o_cmd.emit = 1'b1;
                n_phase    = PH_WS;
            end
        end
    end

    always_comb begin
        if (acc && i_last) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WS;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_last |=> r_out_valid)
        else $error("final byte did not produce a result");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_last |=> r_phase == PH_WS)
        else $error("scan did not restart after the final byte");

    a_nul_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && !i_last && i_status.is_nul |=> r_phase == PH_DONE)
        else $error("zero byte did not end the scan");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> r_out_valid && !i_out_ready)
        else $error("input stalled without a pending result");

    a_emit_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> acc && i_last)
        else $error("result load without a final byte");
`endif

endmodule

FILE: rtl/radix_integer_parser.sv
// Top level of the radix integer parser: configuration register, controller and datapath.
//
// Usage: a string enters one byte per transaction on the input channel (i_valid, o_ready,
// i_char_in, i_last_char). Leading whitespace is skipped, an optional sign is taken, and
// digits of the configured radix (0 auto-detects 0x hex, leading-0 octal, else decimal)
// are folded into a saturating signed 64-bit value. A zero byte ends the scan early.
// The transaction that carries i_last_char produces one result transaction on the output
// channel (o_valid, i_ready, o_value, o_end_pos, o_status) in the next cycle.
// Throughput is one byte per cycle while o_ready is high: each byte takes a single
// pass through the multiply-by-base, add and range-compare path of the datapath.
// A finished result sits in an output register; bytes keep flowing while it waits, and
// the input channel stalls only when a newer result is due and the receiver is stalling.
// The radix register (byte address 0 of the APB port, reset value 10) is sampled at the
// first byte of each string, so it should be written between strings.
// Reset clears the scan state and the pending result and restores the radix to 10.
module radix_integer_parser #(
    parameter int MAX_LEN = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rip_pkg::CHAR_W-1:0]          i_char_in,
    input  logic                                i_last_char,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [rip_pkg::VALUE_W-1:0]  o_value,
    output logic [rip_pkg::END_W-1:0]           o_end_pos,
    output logic [1:0]                          o_status,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rip_pkg::ADDR_W-1:0]          paddr,
    input  logic [rip_pkg::DATA_W-1:0]          pwdata,
    output logic [rip_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    logic [rip_pkg::BASE_W-1:0] r_radix;
    logic                       radix_sel;
    rip_pkg::t_dp_cmd           cmd;
    rip_pkg::t_dp_status        status;

    // The register file holds a single register; other word addresses read as zero.
    assign radix_sel = (paddr[rip_pkg::ADDR_W-1:2] == rip_pkg::REG_RADIX);
    assign pready    = 1'b1;
    assign prdata    = radix_sel ? rip_pkg::DATA_W'(r_radix) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rip_pkg::RADIX_RESET;
        end else if (psel && penable && pwrite && pready && radix_sel) begin
            r_radix <= pwdata[rip_pkg::BASE_W-1:0];
        end
    end

    // The controller walks the scan phases and owns both handshakes.
    rip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_last      (i_last_char),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    // The datapath classifies each byte, accumulates the magnitude and holds the result.
    rip_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_char        (i_char_in),
        .i_radix       (r_radix),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_value       (o_value),
        .o_end_pos     (o_end_pos),
        .o_status_code (o_status)
    );

endmodule

FILE: test/radix_integer_parser_checker.sv
// Checker for the radix integer parser: predicts every parsed number and compares results.
`timescale 1ns / 100ps
module radix_integer_parser_checker #(
    parameter int MAX_LEN = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_char_valid,
    input  logic                               i_char_ready,
    input  logic [rip_pkg::CHAR_W-1:0]         i_char,
    input  logic                               i_last,
    input  logic                               i_num_valid,
    input  logic                               i_num_ready,
    input  logic [rip_pkg::VALUE_W-1:0]        i_value,
    input  logic [rip_pkg::END_W-1:0]          i_end_pos,
    input  logic [1:0]                         i_status,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [rip_pkg::ADDR_W-1:0]         i_paddr,
    input  logic [rip_pkg::DATA_W-1:0]         i_pwdata,
    input  logic                               i_pready,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);

    typedef enum logic [2:0] {
        SCAN_SPACE,
        SCAN_SIGN,
        SCAN_ZERO,
        SCAN_HEX,
        SCAN_DIGITS,
        SCAN_STOP
    } t_scan;

    typedef struct packed {
        logic [rip_pkg::VALUE_W-1:0] value;
        logic [rip_pkg::END_W-1:0]   end_pos;
        logic [1:0]                  status;
    } t_number;

    logic [rip_pkg::BASE_W-1:0]  radix_reg;
    t_scan                       scan;
    logic                        neg;
    logic                        ovf;
    logic                        bad_radix;
    logic [rip_pkg::BASE_W-1:0]  base;
    logic [rip_pkg::VALUE_W-1:0] mag;
    int unsigned                 nbytes;
    int unsigned                 stop_at;
    t_number                     due_numbers[$];
    int                          fail_count = 0;
    int                          checked = 0;

    function automatic int unsigned digit_of(input logic [7:0] c);
        logic [7:0] lc;
        lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
        if (c >= "0" && c <= "9") begin
            return c - "0";
        end else if (lc >= "a" && lc <= "z") begin
            return lc - "a" + 10;
        end
        return 99;
    endfunction

    task clear_scan;
        scan      = SCAN_SPACE;
        neg       = 1'b0;
        ovf       = 1'b0;
        bad_radix = 1'b0;
        base      = '0;
        mag       = '0;
        nbytes    = 0;
        stop_at   = 0;
    endtask

    // Folds one digit in, or stops the scan on a character outside the base.
    task take_digit(input logic [7:0] c, input int unsigned pos);
        int unsigned                 d;
        logic [rip_pkg::VALUE_W-1:0] lim;
        d = digit_of(c);
        if (base == 0 || d >= base) begin
            scan = SCAN_STOP;
            return;
        end
        lim = neg ? rip_pkg::LIM_NEG : rip_pkg::LIM_POS;
        if (!ovf) begin
            if (mag > (lim - 64'(d)) / 64'(base)) begin
                ovf = 1'b1;
            end else begin
                mag = mag * 64'(base) + 64'(d);
            end
        end
        stop_at = pos + 1;
        scan    = SCAN_DIGITS;
    endtask

    task lead_char(input logic [7:0] c, input int unsigned pos);
        if (c == "0" && (base == 0 || base == rip_pkg::BASE_HEX)) begin
            stop_at = pos + 1;
            scan    = SCAN_ZERO;
        end else begin
            if (base == 0) begin
                base = rip_pkg::BASE_DEC;
            end
            take_digit(c, pos);
        end
    endtask

    task scan_char(input logic [7:0] c, input logic last);
        int unsigned pos;
        t_number     n;
        pos = nbytes;
        // The radix is latched at the first byte of every string.
        if (scan == SCAN_SPACE && pos == 0) begin
            if (radix_reg == rip_pkg::RADIX_ONE || radix_reg > rip_pkg::BASE_MAX) begin
                bad_radix = 1'b1;
                scan      = SCAN_STOP;
            end else begin
                base = radix_reg;
            end
        end
        if (scan != SCAN_STOP) begin
            if (c == 8'h00 || pos >= MAX_LEN) begin
                scan = SCAN_STOP;
            end else begin
                nbytes = pos + 1;
                case (scan)
                    SCAN_SPACE: begin
                        if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
                            if (c == "+" || c == "-") begin
                                neg     = (c == "-");
                                stop_at = pos + 1;
                                scan    = SCAN_SIGN;
                            end else begin
                                lead_char(c, pos);
                            end
                        end
                    end
                    SCAN_SIGN: lead_char(c, pos);
                    SCAN_ZERO: begin
                        if (c == "x" || c == "X") begin
                            base = rip_pkg::BASE_HEX;
                            scan = SCAN_HEX;
                        end else begin
                            if (base == 0) begin
                                base = rip_pkg::BASE_OCT;
                            end
                            take_digit(c, pos);
                        end
                    end
                    default: take_digit(c, pos);
                endcase
            end
        end
        if (last) begin
            if (bad_radix) begin
                n.value   = '0;
                n.end_pos = '0;
                n.status  = rip_pkg::ST_BAD_RADIX;
            end else if (ovf) begin
                n.value   = neg ? rip_pkg::LIM_NEG : rip_pkg::LIM_POS;
                n.end_pos = stop_at[rip_pkg::END_W-1:0];
                n.status  = rip_pkg::ST_RANGE;
            end else begin
                n.value   = neg ? -mag : mag;
                n.end_pos = stop_at[rip_pkg::END_W-1:0];
                n.status  = rip_pkg::ST_OK;
            end
            due_numbers.push_back(n);
            clear_scan();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_number want;
        if (!i_rst_n) begin
            radix_reg = rip_pkg::RADIX_RESET;
            clear_scan();
            due_numbers.delete();
        end else begin
            if (i_num_valid && i_num_ready) begin
                if (due_numbers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("Unexpected result: value %0d end_pos %0d status %0d",
                                 $signed(i_value), i_end_pos, i_status);
                    end
                end else begin
                    want = due_numbers.pop_front();
                    checked++;
                    if (i_value !== want.value || i_end_pos !== want.end_pos
                            || i_status !== want.status) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("Mismatch on result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     checked, $signed(want.value), want.end_pos, want.status,
                                     $signed(i_value), i_end_pos, i_status);
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[rip_pkg::ADDR_W-1:2] == rip_pkg::REG_RADIX) begin
                radix_reg = i_pwdata[rip_pkg::BASE_W-1:0];
            end
            if (i_char_valid && i_char_ready) begin
                scan_char(i_char, i_last);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= due_numbers.size();
        o_checked    <= checked;
    end

endmodule

FILE: test/radix_integer_parser_tb.sv
// Testbench top for the radix integer parser: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module radix_integer_parser_tb;

    localparam int MAX_LEN      = 4096;
    localparam int RANDOM_BYTES = 1470;

    // Receiver behavior: always ready, coin toss, or mostly stalled.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SLOW
    } t_rx_mode;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_ready;
    logic [rip_pkg::CHAR_W-1:0]         i_char_in = '0;
    logic                               i_last_char = 1'b0;
    logic                               o_valid;
    logic                               i_ready = 1'b0;
    logic signed [rip_pkg::VALUE_W-1:0] o_value;
    logic [rip_pkg::END_W-1:0]          o_end_pos;
    logic [1:0]                         o_status;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [rip_pkg::ADDR_W-1:0]         paddr = '0;
    logic [rip_pkg::DATA_W-1:0]         pwdata = '0;
    logic [rip_pkg::DATA_W-1:0]         prdata;
    logic                               pready;

    int fail_count;
    int pending;
    int checked;

    // Bytes of the string that is being assembled for the next send.
    logic [7:0]  text_q[$];
    int unsigned burst_left = 0;
    int unsigned bytes_sent = 0;
    int unsigned strings_sent = 0;
    int unsigned radix_writes = 0;
    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;

    radix_integer_parser #(
        .MAX_LEN(MAX_LEN)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_char_in  (i_char_in),
        .i_last_char(i_last_char),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_value    (o_value),
        .o_end_pos  (o_end_pos),
        .o_status   (o_status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // The checker watches both channels and the register port beside the block.
    radix_integer_parser_checker #(
        .MAX_LEN(MAX_LEN)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char_valid(i_valid),
        .i_char_ready(o_ready),
        .i_char      (i_char_in),
        .i_last      (i_last_char),
        .i_num_valid (o_valid),
        .i_num_ready (i_ready),
        .i_value     (o_value),
        .i_end_pos   (o_end_pos),
        .i_status    (o_status),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver switches stall patterns when each random run ends, so that
    // stalls land on every phase of a string, with fully open stretches in between.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_left = $urandom_range(5, 60);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN: i_ready <= 1'b1;
            RX_COIN: i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Hard stop in case a transaction never completes.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Presents one byte and holds it until the transaction completes. The sender works
    // in bursts: when a burst runs out, valid usually drops for a random gap.
    task automatic send_byte(input logic [7:0] c, input logic last);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        i_valid     <= 1'b1;
        i_char_in   <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        bytes_sent++;
    endtask

    // Sends the assembled string; its final byte carries the last flag.
    task automatic send_text;
        for (int k = 0; k < text_q.size(); k++) begin
            send_byte(text_q[k], k == text_q.size() - 1);
        end
        text_q.delete();
        strings_sent++;
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            text_q.push_back(s[k]);
        end
    endtask

    // Drops valid if it is still up from the last transaction.
    task automatic pause_sender;
        if (i_valid) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Radix writes happen only with the block idle: the sender paused and all results back,
    // then a pause before the write. Upper data bits carry random junk.
    task automatic set_radix(input logic [rip_pkg::BASE_W-1:0] rad);
        pause_sender();
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rip_pkg::REG_RADIX, 2'b00};
        pwdata  <= {26'($urandom()), rad};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        radix_writes++;
    endtask

    // Radix plan for the random part: the common bases, the extremes and the invalid
    // values first, then random settings across the whole register range.
    function automatic logic [rip_pkg::BASE_W-1:0] radix_for_phase(input int unsigned idx);
        case (idx)
            0:       return rip_pkg::BASE_DEC;
            1:       return 6'd0;
            2:       return rip_pkg::BASE_HEX;
            3:       return 6'd2;
            4:       return rip_pkg::BASE_MAX;
            5:       return rip_pkg::BASE_OCT;
            6:       return rip_pkg::RADIX_ONE;
            7:       return 6'd37;
            8:       return 6'd63;
            default: return 6'($urandom_range(0, 63));
        endcase
    endfunction

    // Builds one string. Most are well formed numbers with random whitespace, sign,
    // prefix, digit count and tail; about one in ten is raw noise over all byte values.
    task automatic make_number(input logic [rip_pkg::BASE_W-1:0] rad);
        int unsigned n;
        int unsigned d;
        int unsigned eb;
        int unsigned sel;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                sel = $urandom_range(0, 5);
                text_q.push_back(sel == 5 ? 8'h20 : 8'(9 + sel));
            end
        end
        sel = $urandom_range(0, 3);
        if (sel == 1) begin
            push_text("+");
        end else if (sel == 2) begin
            push_text("-");
        end
        if (rad == 0 || (rad >= 2 && rad <= rip_pkg::BASE_MAX)) begin
            eb = rad;
        end else begin
            eb = $urandom_range(2, 36);
        end
        if (rad == 0 || rad == rip_pkg::BASE_HEX) begin
            sel = $urandom_range(0, 3);
            if (sel == 0) begin
                push_text($urandom_range(0, 1) ? "0x" : "0X");
                eb = rip_pkg::BASE_HEX;
            end else if (sel == 1 && rad == 0) begin
                push_text("0");
                eb = rip_pkg::BASE_OCT;
            end
        end
        if (eb == 0) begin
            eb = rip_pkg::BASE_DEC;
        end
        sel = $urandom_range(0, 19);
        n = (sel == 0) ? 0 : (sel < 14) ? $urandom_range(1, 8)
                                        : (sel < 18) ? $urandom_range(9, 22)
                                                     : $urandom_range(23, 70);
        // Now and then land right at the edge of the signed 64-bit range.
        if (eb == rip_pkg::BASE_DEC && $urandom_range(0, 7) == 0) begin
            push_text("922337203685477580");
            n = 1;
        end
        repeat (n) begin
            d = $urandom_range(0, eb - 1);
            if (d < 10) begin
                text_q.push_back(8'("0" + d));
            end else begin
                text_q.push_back(8'(($urandom_range(0, 1) ? "a" : "A") + d - 10));
            end
        end
        sel = $urandom_range(0, 5);
        if (sel == 0) begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end else if (sel == 1) begin
            // A terminator, followed by bytes that must be ignored.
            text_q.push_back(8'h00);
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
        end
        if (text_q.size() == 0) begin
            text_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int unsigned phase_no;
        int unsigned random_goal;
        logic [rip_pkg::BASE_W-1:0] rad;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings at the reset radix of ten: a lone sign after whitespace,
        // a top-bit byte with no digit, the most negative value, a positive overflow,
        // and a terminator that hides the digit after it.
        push_text(" \t+");
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        push_text("-9223372036854775808");
        send_text();
        push_text("9223372036854775808");
        send_text();
        text_q.push_back(8'h00);
        push_text("7");
        send_text();

        // Auto-detection: a bare hex prefix, mixed-case hex, octal, and the most
        // negative value written in hex.
        set_radix(6'd0);
        push_text("0x");
        send_text();
        push_text("0X1fZ");
        send_text();
        push_text("017");
        send_text();
        push_text("-0x8000000000000000");
        send_text();

        set_radix(rip_pkg::BASE_MAX);
        push_text("zZ");
        send_text();
        set_radix(rip_pkg::RADIX_ONE);
        push_text("12");
        send_text();

        // Random strings, a batch per radix setting, until the byte budget is spent.
        random_goal = bytes_sent + RANDOM_BYTES;
        phase_no = 0;
        while (bytes_sent < random_goal) begin
            rad = radix_for_phase(phase_no);
            set_radix(rad);
            repeat ($urandom_range(8, 20)) begin
                if (bytes_sent >= random_goal) break;
                make_number(rad);
                send_text();
            end
            phase_no++;
        end

        // Drain: every expected result back, then a little slack for strays.
        pause_sender();
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d strings (%0d bytes) under %0d radix settings; %0d results checked.",
                 strings_sent, bytes_sent, radix_writes, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
